FILE: rtl/core/lph_pkg.sv
// Shared constants, codes and types for the linear probing hash table.
package lph_pkg;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int TSZ_W    = 9;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int SST_W    = 2;

    // Default store depth and reset value of the table size register.
    localparam int DEPTH_DEF = 256;
    localparam logic [TSZ_W-1:0] TSZ_RESET = 9'd256;

    // Bit counter width of the remainder unit.
    localparam int MOD_CW = $clog2(KEY_W + 1);

    // Request codes.
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result codes.
    localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] RES_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd3;

    // Slot states.
    localparam logic [SST_W-1:0] ST_EMPTY    = 2'd0;
    localparam logic [SST_W-1:0] ST_OCCUPIED = 2'd1;
    localparam logic [SST_W-1:0] ST_DELETED  = 2'd2;

    // Write controls from the sequencer to the slot store.
    typedef struct packed {
        logic             st_we;
        logic             data_we;
        logic [SST_W-1:0] status;
    } t_store_wr;

endpackage

FILE: rtl/core/lph_mod.sv
// Bit-serial remainder unit that computes the home slot of a key.
module lph_mod import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [KEY_W-1:0]                     i_dividend,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     i_divisor,
    output logic                                 o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]       o_rem
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SZW = $clog2(TABLE_DEPTH + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [MOD_CW-1:0] r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_dvd, n_dvd;
    logic [SZW-1:0]    r_div, n_div;
    logic [SZW-1:0]    r_rem, n_rem;
    logic [SZW:0]      rem_sh;

    // One quotient bit per cycle, most significant key bit first.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        rem_sh = {r_rem, r_dvd[KEY_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = MOD_CW'(KEY_W);
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem = SZW'(rem_sh - {1'b0, r_div});
            end else begin
                n_rem = SZW'(rem_sh);
            end
            n_dvd = {r_dvd[KEY_W-2:0], 1'b0};
            n_cnt = r_cnt - MOD_CW'(1);
            if (r_cnt == MOD_CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    // The remainder is below the divisor, which never exceeds the depth.
    assign o_rem  = AW'(r_rem);

endmodule

FILE: rtl/core/lph_store.sv
// Slot store: slot states, keys and payloads with one read and one write port.
module lph_store import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_rd_addr,
    output logic [SST_W-1:0]                  o_rd_status,
    output logic [KEY_W-1:0]                  o_rd_key,
    output logic [VAL_W-1:0]                  o_rd_value,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_wr_addr,
    input  t_store_wr                         i_wr,
    input  logic [KEY_W-1:0]                  i_wr_key,
    input  logic [VAL_W-1:0]                  i_wr_value
);

    logic [SST_W-1:0] r_status_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_key_mem    [TABLE_DEPTH];
    logic [VAL_W-1:0] r_value_mem  [TABLE_DEPTH];
    logic [SST_W-1:0] r_rd_status;
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr.st_we) begin
            r_status_mem[i_wr_addr] <= i_wr.status;
        end
        if (i_wr.data_we) begin
            r_key_mem[i_wr_addr]   <= i_wr_key;
            r_value_mem[i_wr_addr] <= i_wr_value;
        end
        r_rd_status <= r_status_mem[i_rd_addr];
        r_rd_key    <= r_key_mem[i_rd_addr];
        r_rd_value  <= r_value_mem[i_rd_addr];
    end

    assign o_rd_status = r_rd_status;
    assign o_rd_key    = r_rd_key;
    assign o_rd_value  = r_rd_value;

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// Open-addressed hash table with linear probing; sequencer and top level.
//
// Requests enter on i_valid/o_stall with i_operation, i_key and i_value; each
// request gives exactly one result word on o_valid/i_stall carrying o_status,
// o_slot_index and o_value_out. The table size register is written through
// i_cfg_valid/o_cfg_ready, which is always ready.
// One request is worked on at a time. A search, add or remove first runs the
// key through a bit-serial remainder unit, then visits slots one after
// another in two states each (S_PROBE puts out the address, S_CHK checks the
// registered read of the slot store). A clear sweeps every entry of the
// store, one per cycle. The next request is taken once the result is handed
// to the output register.
// After reset the block sweeps every entry of the store to empty and holds
// o_stall high meanwhile; the table size returns to 256.
// While the receiver stalls, the result word holds in the output register; a
// further request may still be worked on and waits until that word is taken.
module linear_probe_hash_table import lph_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VAL_W-1:0]    i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic [VAL_W-1:0]    o_value_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [TSZ_W-1:0]    i_cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int SZW  = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (SZW > TSZ_W) ? SZW : TSZ_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [TSZ_W-1:0]    r_tsz;
    logic                r_clr_op, n_clr_op;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [VAL_W-1:0]    r_value, n_value;
    logic [SZW-1:0]      r_size, n_size;
    logic [AW-1:0]       r_pos, n_pos;
    logic [SZW-1:0]      r_cnt, n_cnt;
    logic                r_free_vld, n_free_vld;
    logic [AW-1:0]       r_free_pos, n_free_pos;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [VAL_W-1:0]    r_res_value, n_res_value;
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [VAL_W-1:0]    r_out_value, n_out_value;

    logic [CMPW-1:0]     tsz_ext;
    logic [SZW-1:0]      eff_size;
    logic [SZW-1:0]      pos_inc;
    logic                mod_start;
    logic                mod_done;
    logic [AW-1:0]       mod_rem;
    logic [SST_W-1:0]    rd_status;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_value;
    logic [AW-1:0]       wr_addr;
    t_store_wr           wr_ctl;
    logic                hit;
    logic                stop;
    logic                free_here;

    // A size of zero acts as one; a size beyond the store acts as its depth.
    assign tsz_ext = CMPW'(r_tsz);
    always_comb begin
        if (tsz_ext == '0) begin
            eff_size = SZW'(1);
        end else if (tsz_ext > CMPW'(TABLE_DEPTH)) begin
            eff_size = SZW'(TABLE_DEPTH);
        end else begin
            eff_size = SZW'(tsz_ext);
        end
    end

    assign pos_inc   = SZW'(r_pos) + SZW'(1);
    assign hit       = (rd_status == ST_OCCUPIED) && (rd_key == r_key);
    assign free_here = (rd_status != ST_OCCUPIED);
    assign stop      = (rd_status == ST_EMPTY) || (r_cnt == r_size);

    lph_mod #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_key),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    lph_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (r_pos),
        .o_rd_status (rd_status),
        .o_rd_key    (rd_key),
        .o_rd_value  (rd_value),
        .i_wr_addr   (wr_addr),
        .i_wr        (wr_ctl),
        .i_wr_key    (r_key),
        .i_wr_value  (r_value)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_op     = r_clr_op;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_size       = r_size;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_free_vld   = r_free_vld;
        n_free_pos   = r_free_pos;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_value  = r_res_value;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_value  = r_out_value;
        mod_start    = 1'b0;
        wr_addr      = r_pos;
        wr_ctl       = '{st_we: 1'b0, data_we: 1'b0, status: ST_EMPTY};

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                wr_ctl.st_we = 1'b1;
                if (r_pos == LAST_ADDR) begin
                    n_pos = '0;
                    if (r_clr_op) begin
                        n_clr_op     = 1'b0;
                        n_res_status = RES_OK;
                        n_res_slot   = '0;
                        n_res_value  = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_pos = r_pos + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_key   = i_key;
                    n_value = i_value;
                    n_size  = eff_size;
                    if (i_operation == OP_CLEAR) begin
                        n_clr_op = 1'b1;
                        n_pos    = '0;
                        n_state  = S_INIT;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_pos      = mod_rem;
                    n_cnt      = SZW'(1);
                    n_free_vld = 1'b0;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_res_slot  = '0;
                n_res_value = '0;
                priority if (hit) begin
                    n_res_status = RES_OK;
                    n_res_slot   = SLOT_W'(r_pos);
                    n_state      = S_DONE;
                    if (r_op == OP_SEARCH) begin
                        n_res_value = rd_value;
                    end else if (r_op == OP_ADD) begin
                        n_res_status = RES_PRESENT;
                    end else begin
                        wr_ctl.st_we  = 1'b1;
                        wr_ctl.status = ST_DELETED;
                    end
                end else if (stop) begin
                    n_state = S_DONE;
                    if (r_op == OP_ADD) begin
                        // The first free slot seen on the way is where the
                        // key goes; none means every slot is occupied.
                        if (r_free_vld || free_here) begin
                            wr_addr        = r_free_vld ? r_free_pos : r_pos;
                            wr_ctl.st_we   = 1'b1;
                            wr_ctl.data_we = 1'b1;
                            wr_ctl.status  = ST_OCCUPIED;
                            n_res_status   = RES_OK;
                            n_res_slot     = SLOT_W'(wr_addr);
                        end else begin
                            n_res_status = RES_FULL;
                        end
                    end else begin
                        n_res_status = RES_NOT_FOUND;
                    end
                end else begin
                    if (free_here && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_pos = r_pos;
                    end
                    n_pos   = (pos_inc == r_size) ? '0 : AW'(pos_inc);
                    n_cnt   = r_cnt + SZW'(1);
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_tsz     <= TSZ_RESET;
            r_clr_op  <= 1'b0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_op  <= n_clr_op;
            r_pos     <= n_pos;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tsz <= i_cfg_data;
            end
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_size       <= n_size;
        r_cnt        <= n_cnt;
        r_free_vld   <= n_free_vld;
        r_free_pos   <= n_free_pos;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_value  <= n_out_value;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_vld;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;
    assign o_value_out  = r_out_value;

    // The remainder unit finishes only while the sequencer waits for it.
    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("remainder unit finished outside the home slot wait");

    // The home slot lies inside the table in use.
    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mod_done && (r_state == S_MOD)) |-> (SZW'(mod_rem) < r_size))
        else $error("home slot beyond the table size");

    // Every probe stays inside the table and within one lap.
    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |->
            ((SZW'(r_pos) < r_size) && (r_cnt != '0) && (r_cnt <= r_size)))
        else $error("probe position or count out of range");

    // A new result word appears only when the sequencer hands one over.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word without a finished request");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the linear probing hash table with a slot-store predictor.
module testbench;
    import lph_pkg::*;

    localparam logic [KEY_W-1:0] KEY_ALL = {KEY_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_ALL = {VAL_W{1'b1}};
    localparam int MAX_REPORTS     = 100;
    localparam int POOL_N          = 24;
    localparam int PHASE_N         = 12;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int TAIL_CYCLES     = 600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [VAL_W-1:0]    data;
    } t_lookup_word;

    class probe_table_tracker;
        logic [SST_W-1:0] slot_state [DEPTH_DEF];
        logic [KEY_W-1:0] slot_keys  [DEPTH_DEF];
        logic [VAL_W-1:0] slot_data  [DEPTH_DEF];
        logic [TSZ_W-1:0] size_reg;
        t_lookup_word     awaited [$];
        int               mismatch_count;

        function new();
            size_reg = TSZ_RESET;
            mismatch_count = 0;
            foreach (slot_state[i]) begin
                slot_state[i] = ST_EMPTY;
                slot_keys[i] = '0;
                slot_data[i] = '0;
            end
        endfunction

        function void set_size(logic [TSZ_W-1:0] d);
            size_reg = d;
        endfunction

        // Out-of-range sizes clamp to one slot or to the full store.
        function int unsigned live_span();
            if (size_reg == '0)
                return 1;
            if (32'(size_reg) > DEPTH_DEF)
                return DEPTH_DEF;
            return 32'(size_reg);
        endfunction

        // Deleted slots keep the probe going; an empty slot ends it.
        function bit locate(logic [KEY_W-1:0] key, int unsigned span,
                            output int unsigned where);
            int unsigned pos;
            where = 0;
            pos = key % span;
            for (int unsigned n = 0; n < span; n++) begin
                if (slot_state[pos] == ST_EMPTY)
                    return 1'b0;
                if (slot_state[pos] == ST_OCCUPIED && slot_keys[pos] == key) begin
                    where = pos;
                    return 1'b1;
                end
                pos = (pos + 1) % span;
            end
            return 1'b0;
        endfunction

        function t_lookup_word apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] value);
            t_lookup_word res;
            int unsigned  span;
            int unsigned  where;
            int unsigned  pos;
            bit           placed;
            res = '0;
            span = live_span();
            case (op)
                OP_SEARCH: begin
                    if (locate(key, span, where)) begin
                        res.slot = where[SLOT_W-1:0];
                        res.data = slot_data[where];
                    end else begin
                        res.status = RES_NOT_FOUND;
                    end
                end
                OP_ADD: begin
                    if (locate(key, span, where)) begin
                        res.status = RES_PRESENT;
                        res.slot = where[SLOT_W-1:0];
                    end else begin
                        res.status = RES_FULL;
                        pos = key % span;
                        placed = 1'b0;
                        for (int unsigned n = 0; n < span && !placed; n++) begin
                            if (slot_state[pos] != ST_OCCUPIED) begin
                                slot_state[pos] = ST_OCCUPIED;
                                slot_keys[pos] = key;
                                slot_data[pos] = value;
                                res.status = RES_OK;
                                res.slot = pos[SLOT_W-1:0];
                                placed = 1'b1;
                            end else begin
                                pos = (pos + 1) % span;
                            end
                        end
                    end
                end
                OP_REMOVE: begin
                    if (locate(key, span, where)) begin
                        slot_state[where] = ST_DELETED;
                        res.slot = where[SLOT_W-1:0];
                    end else begin
                        res.status = RES_NOT_FOUND;
                    end
                end
                default: begin
                    // Clear empties the whole store, not only the slots in use.
                    foreach (slot_state[i])
                        slot_state[i] = ST_EMPTY;
                end
            endcase
            return res;
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            awaited.push_back(apply_request(op, key, value));
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task match_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                          logic [VAL_W-1:0] data);
            t_lookup_word want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result word with nothing awaited: status %0d slot %0d",
                                          status, slot));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (slot !== want.slot)
                report_mismatch($sformatf("slot_index got %0d want %0d", slot, want.slot));
            if (data !== want.data)
                report_mismatch($sformatf("value_out got %08h want %08h", data, want.data));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation;
    logic [KEY_W-1:0]    i_key;
    logic [VAL_W-1:0]    i_value;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [VAL_W-1:0]    o_value_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TSZ_W-1:0]    i_cfg_data;

    probe_table_tracker tracker;
    int unsigned        send_pct;
    int unsigned        recv_pct;
    logic [KEY_W-1:0]   key_pool [POOL_N];
    logic [TSZ_W-1:0]   phase_sizes [PHASE_N];

    linear_probe_hash_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_value_out  (o_value_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            tracker.match_result(o_status, o_slot_index, o_value_out);
    end

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin
                send_pct = 17;
                recv_pct = 67;
            end
            1: begin
                send_pct = 67;
                recv_pct = 17;
            end
            default: begin
                send_pct = 0;
                recv_pct = 0;
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_value     <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.take_request(op, key, value);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_table_size(input logic [TSZ_W-1:0] d);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_size(d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A mix of wide keys, keys near the top of the range, small keys and keys sharing one home slot.
    task automatic refill_key_pool(input int unsigned span);
        logic [31:0] rnd;
        logic [31:0] base;
        base = $urandom_range(0, 1023);
        foreach (key_pool[i]) begin
            rnd = $urandom();
            case ($urandom_range(0, 3))
                0: key_pool[i] = rnd[KEY_W-1:0];
                1: key_pool[i] = KEY_ALL - KEY_W'(rnd[5:0]);
                2: begin
                    rnd = base + span * i;
                    key_pool[i] = rnd[KEY_W-1:0];
                end
                default: key_pool[i] = KEY_W'(rnd[9:0]);
            endcase
        end
    endtask

    task automatic random_request();
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [31:0]      rnd;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_ADD;
        else if (pick < 72)
            op = OP_SEARCH;
        else if (pick < 96)
            op = OP_REMOVE;
        else
            op = OP_CLEAR;
        rnd = $urandom();
        if ($urandom_range(0, 9) < 8)
            key = key_pool[$urandom_range(0, POOL_N - 1)];
        else
            key = rnd[KEY_W-1:0];
        send_request(op, key, $urandom());
    endtask

    task automatic run_directed();
        send_request(OP_SEARCH, '0, '0);
        // Top key lands on the last slot; a second key with that home wraps to slot 0.
        send_request(OP_ADD, KEY_ALL, VAL_ALL);
        send_request(OP_ADD, 31'd511, 32'h0000_0001);
        send_request(OP_SEARCH, 31'd511, '0);
        send_request(OP_ADD, KEY_ALL, '0);
        send_request(OP_REMOVE, KEY_ALL, '0);
        // The probe has to step over the deleted slot.
        send_request(OP_SEARCH, 31'd511, '0);
        send_request(OP_ADD, 31'd767, '0);
        send_request(OP_REMOVE, 31'd12345, '0);
        send_request(OP_CLEAR, '0, VAL_ALL);
        send_request(OP_SEARCH, 31'd511, '0);
        // A size of zero behaves as a single slot.
        write_table_size('0);
        send_request(OP_ADD, 31'd5, 32'hA5A5_5A5A);
        send_request(OP_ADD, 31'd6, '0);
        send_request(OP_SEARCH, 31'd6, '0);
        send_request(OP_REMOVE, 31'd5, '0);
        send_request(OP_ADD, 31'd6, 32'h1234_5678);
        send_request(OP_SEARCH, 31'd5, '0);
        send_request(OP_SEARCH, 31'd6, '0);
        write_table_size({TSZ_W{1'b1}});
        send_request(OP_ADD, 31'd300, VAL_ALL);
        send_request(OP_SEARCH, 31'd300, '0);
        // Shrinking leaves the slot of key 300 outside the probed range.
        write_table_size(9'd4);
        send_request(OP_SEARCH, 31'd300, '0);
        send_request(OP_ADD, 31'd300, '0);
    endtask

    initial begin
        int unsigned guard;
        tracker = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_SEARCH;
        i_key       = '0;
        i_value     = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        phase_sizes = '{9'd1, 9'd2, 9'd7, 9'd256, 9'd3, 9'd16, 9'd0, 9'd511,
                        9'd5, 9'd257, 9'd12, 9'd9};
        set_idle_mode(0);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The store is swept to empty after reset while input is held off.
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
        run_directed();
        for (int p = 0; p < PHASE_N; p++) begin
            set_idle_mode(p / 4);
            write_table_size(phase_sizes[p]);
            refill_key_pool(tracker.live_span());
            repeat (ITEMS_PER_PHASE) begin
                sender_gap();
                if ($urandom_range(0, 99) < 2)
                    wait_all_results();
                random_request();
            end
        end
        i_valid <= 1'b0;
        guard = 0;
        while (tracker.awaited.size() != 0 && guard < 400000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (tracker.awaited.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected result words never arrived",
                                              tracker.awaited.size()));
        if (tracker.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
